### rtl/greedy_stack_tops_sorter_macros.svh
// Assertion macros for the pile-top sorter checker.
`ifndef GREEDY_STACK_TOPS_SORTER_MACROS_SVH
`define GREEDY_STACK_TOPS_SORTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GSTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gsts check failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted
`define GSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gsts check failed (next cycle)");

`endif

### rtl/gsts_pkg.sv
// Shared types and constants for the pile-top sorter.
package gsts_pkg;

	localparam int WORD_W      = 32;
	localparam int QUEUE_DEPTH = 4;

	// Result kinds
	localparam logic KIND_COUNT = 1'b0;
	localparam logic KIND_TOP   = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              set_end;
	} in_item_t;

	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] word;
		logic              overflow;
		logic              run_last;
	} out_item_t;

endpackage

### rtl/gsts_fifo.sv
// Small register queue used on the input and result sides.
module gsts_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    fill_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (fill_q == CW'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	// Storage slots
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule

### rtl/gsts_engine.sv
// Back end: binary search over the pile tops, placement and set readout.
module gsts_engine #(
	parameter int MAX_PILES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_empty,
	input  gsts_pkg::in_item_t   in_item,
	output logic                 in_pop,
	input  logic                 out_full,
	output logic                 out_push,
	output gsts_pkg::out_item_t  out_item
);
	import gsts_pkg::*;

	localparam int AW = (MAX_PILES > 1) ? $clog2(MAX_PILES) : 1;
	localparam int CW = $clog2(MAX_PILES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_PLACE,
		ST_EMIT_CNT,
		ST_EMIT_TOP
	} state_t;

	state_t            state_q;
	logic [WORD_W-1:0] v_q;
	logic              last_q;
	logic [CW-1:0]     lo_q;
	logic [CW-1:0]     hi_q;
	logic [AW-1:0]     mid_q;
	logic [CW-1:0]     count_q;
	logic              ovf_q;
	logic [AW-1:0]     idx_q;

	logic [WORD_W-1:0] tops_mem [MAX_PILES];
	logic [WORD_W-1:0] rd_q;

	logic              mem_re;
	logic [AW-1:0]     mem_ra;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;

	logic [CW-1:0]     s_lo;
	logic [CW-1:0]     s_hi;
	logic [CW:0]       s_sum;
	logic [AW-1:0]     s_mid;
	logic              s_more;
	logic              probe_gt;
	logic              top_last;
	logic              has_room;
	logic              hit;

	// Search window for the current cycle: fresh at accept, narrowed in probe
	assign probe_gt = (rd_q > v_q);
	always_comb begin
		if (state_q == ST_PROBE) begin
			s_lo = probe_gt ? lo_q : CW'(mid_q) + CW'(1);
			s_hi = probe_gt ? CW'(mid_q) : hi_q;
		end else begin
			s_lo = '0;
			s_hi = count_q;
		end
	end
	assign s_sum  = {1'b0, s_lo} + {1'b0, s_hi};
	assign s_mid  = s_sum[AW:1];
	assign s_more = (s_lo < s_hi);

	assign hit      = (lo_q < count_q);
	assign has_room = (count_q < CW'(MAX_PILES));
	assign top_last = ((CW'(idx_q) + CW'(1)) == count_q);

	// Memory port control and result formatting
	always_comb begin
		in_pop   = 1'b0;
		mem_re   = 1'b0;
		mem_ra   = s_mid;
		mem_we   = 1'b0;
		mem_wa   = lo_q[AW-1:0];
		out_push = 1'b0;
		out_item = '{kind: KIND_COUNT, word: WORD_W'(count_q), overflow: ovf_q,
			run_last: (count_q == '0)};
		unique case (state_q)
			ST_IDLE: begin
				in_pop = !in_empty;
				mem_re = !in_empty && s_more;
			end
			ST_PROBE: begin
				mem_re = s_more;
			end
			ST_PLACE: begin
				if (hit) begin
					mem_we = 1'b1;
				end else if (has_room) begin
					mem_we = 1'b1;
					mem_wa = count_q[AW-1:0];
				end
			end
			ST_EMIT_CNT: begin
				out_push = !out_full;
				mem_re   = !out_full && (count_q != '0);
				mem_ra   = '0;
			end
			ST_EMIT_TOP: begin
				out_push = !out_full;
				mem_re   = !out_full && !top_last;
				mem_ra   = idx_q + AW'(1);
				out_item = '{kind: KIND_TOP, word: rd_q, overflow: ovf_q,
					run_last: top_last};
			end
			default: begin
				in_pop = 1'b0;
			end
		endcase
	end

	// Pile-top store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tops_mem[mem_wa] <= v_q;
		end
		if (mem_re) begin
			rd_q <= tops_mem[mem_ra];
		end
	end

	// Item payload and search window
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && !in_empty) begin
			v_q    <= in_item.value;
			last_q <= in_item.set_end;
		end
		if ((state_q == ST_IDLE && !in_empty) || state_q == ST_PROBE) begin
			lo_q  <= s_lo;
			hi_q  <= s_hi;
			mid_q <= s_mid;
		end
		if (state_q == ST_EMIT_CNT) begin
			idx_q <= '0;
		end else if (state_q == ST_EMIT_TOP && !out_full) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	// Sequencer with pile count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!in_empty) begin
						state_q <= s_more ? ST_PROBE : ST_PLACE;
					end
				end
				ST_PROBE: begin
					if (!s_more) begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					if (!hit) begin
						if (has_room) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					state_q <= last_q ? ST_EMIT_CNT : ST_IDLE;
				end
				ST_EMIT_CNT: begin
					if (!out_full) begin
						if (count_q == '0) begin
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT_TOP;
						end
					end
				end
				ST_EMIT_TOP: begin
					if (!out_full && top_last) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/greedy_stack_tops_sorter.sv
// Top level of the patience-sort pile-top tracker: input queue, search engine, result queue.
// Per item: an accept step, probe steps (one memory read each), then a place step.
// A set_end adds the count, then each top, one per cycle unless the result queue is full.
// Input-to-engine and engine-to-output each pass through a 4-entry queue.
// Reset (arst_n low) empties both queues and clears pile count and overflow at once.
module greedy_stack_tops_sorter #(
	parameter int MAX_PILES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gsts_pkg::in_item_t  item,
	output logic                full,
	input  logic                pop,
	output gsts_pkg::out_item_t result,
	output logic                empty
);
	import gsts_pkg::*;

	in_item_t  q_item;
	logic      q_empty;
	logic      q_pop;
	out_item_t e_item;
	logic      e_push;
	logic      e_full;

	// Front: input queue
	gsts_fifo #(
		.WIDTH($bits(in_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (item),
		.full  (full),
		.pop   (q_pop),
		.dout  (q_item),
		.empty (q_empty)
	);

	// Back: search, place and readout
	gsts_engine #(
		.MAX_PILES(MAX_PILES)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_empty(q_empty),
		.in_item (q_item),
		.in_pop  (q_pop),
		.out_full(e_full),
		.out_push(e_push),
		.out_item(e_item)
	);

	// Result queue
	gsts_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_results (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (e_push),
		.din   (e_item),
		.full  (e_full),
		.pop   (pop),
		.dout  (result),
		.empty (empty)
	);

endmodule

### rtl/gsts_checker.sv
// Port-level checks for the pile-top sorter, bound to the top level.
`include "greedy_stack_tops_sorter_macros.svh"

module gsts_checker #(
	parameter int MAX_PILES = 32
) (
	input logic                clk,
	input logic                arst_n,
	input logic                pop,
	input gsts_pkg::out_item_t result,
	input logic                empty
);
	import gsts_pkg::*;

	logic is_count;
	logic mid_pop;

	// Shorthands: count word on the ports, non-final result transferred
	assign is_count = !empty && result.kind == KIND_COUNT;
	assign mid_pop  = !empty && pop && !result.run_last;

	// A waiting result stays until popped
	`GSTS_ASSERT_NEXT(a_result_held, clk, arst_n, !empty && !pop, !empty && $stable(result))

	// Count word is flagged last exactly when no pile exists
	`GSTS_ASSERT_NOW(a_count_last, clk, arst_n, is_count, result.run_last == (result.word == '0))

	// Pile count never exceeds capacity
	`GSTS_ASSERT_NOW(a_count_cap, clk, arst_n, is_count, result.word <= WORD_W'(MAX_PILES))

	// A transferred result that is not last is followed by a top of the set or an empty queue
	`GSTS_ASSERT_NEXT(a_top_follows, clk, arst_n, mid_pop, empty || result.kind == KIND_TOP)

endmodule

bind greedy_stack_tops_sorter gsts_checker #(.MAX_PILES(MAX_PILES)) u_gsts_checker (.*);

### tb/greedy_stack_tops_sorter_tb.sv
// Self-checking testbench for the patience-sort pile-top tracker.
`timescale 1ns / 1ps

module greedy_stack_tops_sorter_tb;

	import gsts_pkg::*;

	localparam int PILE_CAP    = 32;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_TAIL  = 64;

	// Value patterns for random sets
	typedef enum int {
		PAT_FULL,
		PAT_SMALL,
		PAT_NEAR_MAX,
		PAT_ASCEND
	} value_pat_e;

	logic      clk;
	logic      arst_n;
	logic      push;
	in_item_t  item;
	logic      full;
	logic      pop = 1'b0;
	out_item_t result;
	logic      empty;

	// Pile model and the readout words it has predicted
	logic [WORD_W-1:0] tops_model [PILE_CAP];
	int                piles_used;
	logic              dropped_any;
	out_item_t         expected_readout [$];

	int send_idle_pct;
	int recv_idle_pct;
	int mismatches = 0;
	int cycle_count = 0;

	greedy_stack_tops_sorter #(
		.MAX_PILES(PILE_CAP)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.item  (item),
		.full  (full),
		.pop   (pop),
		.result(result),
		.empty (empty)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("greedy_stack_tops_sorter_tb: errors");
			$finish;
		end
	end

	// Place one value on the piles; a set end appends the readout words
	function automatic void place_on_piles(input logic [WORD_W-1:0] v, input logic last);
		int        pos;
		out_item_t word_out;
		pos = 0;
		while (pos < piles_used && tops_model[pos] <= v)
			pos++;
		if (pos < piles_used) begin
			tops_model[pos] = v;
		end else if (piles_used < PILE_CAP) begin
			tops_model[piles_used] = v;
			piles_used++;
		end else begin
			dropped_any = 1'b1;
		end
		if (last) begin
			word_out.kind     = KIND_COUNT;
			word_out.word     = WORD_W'(piles_used);
			word_out.overflow = dropped_any;
			word_out.run_last = (piles_used == 0);
			expected_readout = {expected_readout, word_out};
			for (int i = 0; i < piles_used; i++) begin
				word_out.kind     = KIND_TOP;
				word_out.word     = tops_model[i];
				word_out.overflow = dropped_any;
				word_out.run_last = (i + 1 == piles_used);
				expected_readout = {expected_readout, word_out};
			end
			piles_used  = 0;
			dropped_any = 1'b0;
		end
	endfunction

	// Result side: random pop, compare each transfer with the oldest prediction
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (expected_readout.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0b word %h ovf %0b last %0b",
						result.kind, result.word, result.overflow, result.run_last);
			end else begin
				want = expected_readout.pop_front();
				if (result.kind !== want.kind || result.word !== want.word ||
					result.overflow !== want.overflow || result.run_last !== want.run_last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch: exp kind %0b word %h ovf %0b last %0b",
							want.kind, want.word, want.overflow, want.run_last);
						$display(" / got kind %0b word %h ovf %0b last %0b",
							result.kind, result.word, result.overflow, result.run_last);
					end
				end
			end
		end
	end

	// Send one value; push stays high after the transfer for back-to-back items
	task automatic push_value(input logic [WORD_W-1:0] v, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= '{value: v, set_end: last};
		do
			@(posedge clk);
		while (full);
		place_on_piles(v, last);
	endtask

	// Hold off the sender until every predicted word has been read out
	task automatic wait_for_readout();
		push <= 1'b0;
		@(posedge clk);
		while (expected_readout.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] next_value(input value_pat_e pat,
		input logic [WORD_W-1:0] prev);
		logic [WORD_W-1:0] v;
		case (pat)
			PAT_FULL:     v = $urandom;
			PAT_SMALL:    v = $urandom_range(15);
			PAT_NEAR_MAX: v = 32'hFFFF_FFFF - $urandom_range(15);
			default: begin
				// mostly rising with repeats, an occasional dip
				if ($urandom_range(9) == 0)
					v = $urandom_range(255);
				else
					v = prev + $urandom_range(3);
			end
		endcase
		return v;
	endfunction

	// Extremes, equal values, replacement chains
	task automatic test_directed_cases();
		push_value(32'h0000_0000, 1'b1);
		push_value(32'hFFFF_FFFF, 1'b0);
		push_value(32'h0000_0000, 1'b1);
		push_value(32'h0000_0000, 1'b0);
		push_value(32'hFFFF_FFFF, 1'b1);
		push_value(32'hAAAA_AAAA, 1'b0);
		push_value(32'h5555_5555, 1'b1);
		// equal values open new piles
		push_value(32'd5, 1'b0);
		push_value(32'd5, 1'b0);
		push_value(32'd5, 1'b1);
		push_value(32'd5, 1'b0);
		push_value(32'd5, 1'b0);
		push_value(32'd3, 1'b1);
		// strictly falling: one pile
		push_value(32'd9, 1'b0);
		push_value(32'd7, 1'b0);
		push_value(32'd4, 1'b0);
		push_value(32'd1, 1'b1);
		push_value(32'd3, 1'b0);
		push_value(32'd8, 1'b0);
		push_value(32'd8, 1'b0);
		push_value(32'd2, 1'b0);
		push_value(32'd9, 1'b0);
		push_value(32'd8, 1'b1);
	endtask

	// Pile capacity: drops, replacements once full, flag cleared afterward
	task automatic test_pile_overflow();
		logic [WORD_W-1:0] base;
		logic [WORD_W-1:0] v;
		base = $urandom_range(1000);
		v    = base;
		for (int i = 0; i < 36; i++) begin
			push_value(v, 1'b0);
			v = v + $urandom_range(1, 1 << 20);
		end
		push_value(base, 1'b1);
		wait_for_readout();
		// equal maximum values; the marked one is dropped
		for (int i = 0; i < 33; i++)
			push_value(32'hFFFF_FFFF, i == 32);
		push_value(32'd7, 1'b1);
	endtask

	// Well-formed sets of random length and content
	task automatic test_random_sets(input int budget);
		int                sent;
		int                len;
		value_pat_e        pat;
		logic [WORD_W-1:0] v;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(99) < 10) begin
				len = $urandom_range(33, 40);
				pat = PAT_ASCEND;
			end else begin
				len = $urandom_range(1, 10);
				pat = value_pat_e'($urandom_range(3));
			end
			v = $urandom;
			for (int k = 0; k < len; k++) begin
				v = next_value(pat, v);
				push_value(v, k == len - 1);
				sent++;
			end
			if ($urandom_range(99) < 5)
				wait_for_readout();
		end
	endtask

	// Main sequence
	initial begin
		arst_n        = 1'b0;
		push          = 1'b0;
		item          = '0;
		piles_used    = 0;
		dropped_any   = 1'b0;
		send_idle_pct = 15;
		recv_idle_pct = 74;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_pile_overflow();
		test_random_sets(70);
		wait_for_readout();

		send_idle_pct = 74;
		recv_idle_pct = 15;
		test_random_sets(60);
		wait_for_readout();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_sets(60);

		wait_for_readout();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatches == 0 && expected_readout.size() == 0) begin
			$display("greedy_stack_tops_sorter_tb: clean");
		end else begin
			$display("greedy_stack_tops_sorter_tb: errors");
		end
		$finish;
	end

endmodule
